/* hw/rtl/vhrc_pkg.sv */
`timescale 1ns / 1ps

package vhrc_pkg;

  // operand widths
  localparam int unsigned DataW = 32;
  localparam int unsigned ScaleW = 11;
  localparam int unsigned NumW = DataW + ScaleW;
  localparam int unsigned PosW = 11;
  localparam int unsigned ChanW = 8;

  // ring geometry: six segments of full intensity steps
  localparam int unsigned Intensity = 255;
  localparam int unsigned EndSegment = 5;
  localparam int unsigned RingSegments = 6;
  localparam int unsigned ScaleFactor = Intensity * EndSegment;
  localparam int unsigned RingLen = Intensity * RingSegments;

  // configuration register indexes
  localparam logic RegThreshold = 1'b0;
  localparam logic RegMax = 1'b1;

  localparam logic [DataW-1:0] ThresholdReset = 32'sd0;
  localparam logic [DataW-1:0] MaxReset = 32'sd65535;

  // one beat moving through the divider pipeline
  typedef struct packed {
    logic             valid;
    logic             below;
    logic [DataW-1:0] rem;
    logic [NumW-1:0]  num;
    logic [PosW-1:0]  pos;
  } div_beat_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // color of a ring position 0 .. RingLen-1
  function automatic rgb_t ring_color(logic [PosW-1:0] pos);
    rgb_t c;
    logic [PosW-1:0] k;
    logic [PosW-1:0] diff;
    k = PosW'(Intensity);
    c = '0;
    diff = '0;
    if (pos <= k) begin
      c.green = pos[ChanW-1:0];
      c.blue  = ChanW'(Intensity);
    end else if (pos <= PosW'(2 * Intensity)) begin
      diff    = PosW'(2 * Intensity) - pos;
      c.green = ChanW'(Intensity);
      c.blue  = diff[ChanW-1:0];
    end else if (pos <= PosW'(3 * Intensity)) begin
      diff    = pos - PosW'(2 * Intensity);
      c.red   = diff[ChanW-1:0];
      c.green = ChanW'(Intensity);
    end else if (pos <= PosW'(4 * Intensity)) begin
      diff    = PosW'(4 * Intensity) - pos;
      c.red   = ChanW'(Intensity);
      c.green = diff[ChanW-1:0];
    end else if (pos <= PosW'(5 * Intensity)) begin
      diff    = pos - PosW'(4 * Intensity);
      c.red   = ChanW'(Intensity);
      c.blue  = diff[ChanW-1:0];
    end else begin
      diff    = PosW'(6 * Intensity) - pos;
      c.red   = diff[ChanW-1:0];
      c.blue  = ChanW'(Intensity);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/vhrc_div_stage.sv */
`timescale 1ns / 1ps

module vhrc_div_stage
  import vhrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DataW-1:0] den_i,
  input  div_beat_t        beat_i,
  output div_beat_t        beat_o
);

  logic [DataW:0]  trial;
  logic            take;
  logic [DataW:0]  trial_sub;
  logic [PosW:0]   pos_dbl;
  logic [PosW:0]   pos_sub;
  div_beat_t       beat_d;
  div_beat_t       beat_q;

  // one restoring division step, next numerator bit shifted in
  assign trial     = {beat_i.rem, beat_i.num[NumW-1]};
  assign take      = (trial >= {1'b0, den_i});
  assign trial_sub = trial - {1'b0, den_i};

  // quotient bit folded into the running ring position
  assign pos_dbl = {beat_i.pos, take};
  assign pos_sub = pos_dbl - (PosW + 1)'(RingLen);

  always_comb begin
    beat_d       = beat_i;
    beat_d.rem   = take ? trial_sub[DataW-1:0] : trial[DataW-1:0];
    beat_d.num   = {beat_i.num[NumW-2:0], 1'b0};
    beat_d.pos   = (pos_dbl >= (PosW + 1)'(RingLen)) ? pos_sub[PosW-1:0] : pos_dbl[PosW-1:0];
  end

  // stage register, valid bit cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

/* hw/rtl/value_to_hue_ring_color_core.sv */
`timescale 1ns / 1ps

// Pseudo-color map: one signed 32-bit sample in, one 8-bit RGB beat out.
// Input: a sample is taken at each rising edge with start high; busy stays
// low, so a new sample may enter in every cycle.
// Output: result_valid_o is high for one cycle with red/green/blue and
// range_error; the receiver must take it in that cycle.
// Throughput is one sample per cycle. The pipeline holds an input stage, a
// multiply-by-1275 stage, the restoring divider with one quotient bit per
// stage over 43 stages, and the color output register.
// Registers threshold_value (0x0) and max_value (0x4) are written through the
// APB port; the user must do so only while no sample is in flight, as the block
// itself does not enforce it.
// Reset clears the pipeline valid bits and loads threshold 0 and max 65535.
// Black results when the sample lies below threshold; black with range_error
// when max is not above threshold.
module value_to_hue_ring_color_core
  import vhrc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready,
  // sample channel
  input  logic                    start,
  output logic                    busy,
  input  logic signed [DataW-1:0] sample_value_i,
  // result channel
  output logic                    result_valid_o,
  output logic [ChanW-1:0]        red_o,
  output logic [ChanW-1:0]        green_o,
  output logic [ChanW-1:0]        blue_o,
  output logic                    range_error_o
);

  localparam int unsigned Stages = NumW;

  logic [DataW-1:0] thr_q, thr_d;
  logic [DataW-1:0] max_q, max_d;
  logic [DataW-1:0] den_q;
  logic [DataW:0]   den_d;
  logic             rerr_q, rerr_d;
  logic             wr_en;

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign prdata = (paddr[2] == RegMax) ? max_q : thr_q;

  always_comb begin
    thr_d = thr_q;
    max_d = max_q;
    if (wr_en) begin
      case (paddr[2])
        RegThreshold: thr_d = pwdata;
        RegMax:       max_d = pwdata;
        default:      thr_d = thr_q;
      endcase
    end
    den_d  = {max_d[DataW-1], max_d} - {thr_d[DataW-1], thr_d};
    rerr_d = ($signed(max_d) <= $signed(thr_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThresholdReset;
      max_q  <= MaxReset;
      den_q  <= MaxReset - ThresholdReset;
      rerr_q <= 1'b0;
    end else begin
      thr_q  <= thr_d;
      max_q  <= max_d;
      den_q  <= den_d[DataW-1:0];
      rerr_q <= rerr_d;
    end
  end

  assign busy = 1'b0;

  // input stage: offset from threshold
  logic             in_valid_q;
  logic             in_below_q;
  logic [DataW-1:0] in_diff_q;
  logic [DataW:0]   in_diff_d;

  assign in_diff_d = {sample_value_i[DataW-1], sample_value_i} - {thr_q[DataW-1], thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_below_q <= in_diff_d[DataW];
    in_diff_q  <= in_diff_d[DataW-1:0];
  end

  // scale stage: offset times 1275
  div_beat_t       chain [Stages+1];
  div_beat_t       scale_d;
  div_beat_t       scale_q;
  logic [NumW-1:0] scaled;

  assign scaled = NumW'(in_diff_q) * NumW'(ScaleFactor);

  always_comb begin
    scale_d       = '0;
    scale_d.valid = in_valid_q;
    scale_d.below = in_below_q;
    scale_d.num   = scaled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else begin
      scale_q <= scale_d;
    end
  end

  assign chain[0] = scale_q;

  // divider pipeline, quotient reduced modulo the ring length on the fly
  for (genvar i = 0; i < Stages; i++) begin : g_div
    vhrc_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .den_i  (den_q),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  // color output register
  div_beat_t last;
  rgb_t      color;

  assign last  = chain[Stages];
  assign color = ring_color(last.pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rerr_q || last.below) begin
      red_o   <= '0;
      green_o <= '0;
      blue_o  <= '0;
    end else begin
      red_o   <= color.red;
      green_o <= color.green;
      blue_o  <= color.blue;
    end
    range_error_o <= rerr_q;
  end

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##46 result_valid_o)
    else $error("result beat missing after pipeline latency");

  a_err_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && range_error_o) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("range error beat is not black");

  a_one_dark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (red_o == '0 || green_o == '0 || blue_o == '0))
    else $error("ring color has no dark channel");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid |-> (last.pos < PosW'(RingLen)))
    else $error("ring position out of range");

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && !rerr_q) |-> (last.rem < den_q))
    else $error("division remainder not below divisor");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import vhrc_pkg::*;
();

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles = 60;
  localparam logic [2:0] AddrThreshold = {RegThreshold, 2'b00};
  localparam logic [2:0] AddrMax = {RegMax, 2'b00};
  localparam longint Full = Intensity;
  localparam longint ScaleSteps = Intensity * EndSegment;
  localparam longint RingSteps = Intensity * RingSegments;
  localparam longint MinS32 = -64'sd2147483648;
  localparam longint MaxS32 = 64'sd2147483647;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             range_error;
  } hue_beat_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [2:0]              paddr = '0;
  logic [DataW-1:0]        pwdata = '0;
  logic [DataW-1:0]        prdata;
  logic                    pready;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [DataW-1:0] sample_value = '0;
  logic                    result_valid_o;
  logic [ChanW-1:0]        red_o;
  logic [ChanW-1:0]        green_o;
  logic [ChanW-1:0]        blue_o;
  logic                    range_error_o;

  // our copy of the color scale registers
  logic signed [DataW-1:0] scale_low = 32'sd0;
  logic signed [DataW-1:0] scale_top = 32'sd65535;

  logic signed [DataW-1:0] samples_to_send[$];
  hue_beat_t               hues_due[$];
  int unsigned             send_idle_pct = 0;
  int unsigned             mismatches = 0;
  int unsigned             beats_in = 0;
  int unsigned             beats_out = 0;
  int unsigned             range_error_beats = 0;
  int unsigned             black_beats = 0;
  int unsigned             settings_used = 1;
  int unsigned             quiet_cycles = 0;

  value_to_hue_ring_color_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .sample_value_i (sample_value),
    .result_valid_o (result_valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .range_error_o  (range_error_o)
  );

  always #5 clk_i = ~clk_i;

  // expected color of one sample on the hue ring
  function automatic hue_beat_t hue_of(logic signed [DataW-1:0] smp,
                                       logic signed [DataW-1:0] low,
                                       logic signed [DataW-1:0] top);
    hue_beat_t h;
    longint    s;
    longint    t;
    longint    m;
    longint    pos;
    longint    off;
    h = '0;
    s = smp;
    t = low;
    m = top;
    if (m <= t) begin
      h.range_error = 1'b1;
    end else if (s >= t) begin
      pos = (((s - t) * ScaleSteps) / (m - t)) % RingSteps;
      off = pos % Full;
      case (pos / Full)
        // blue to cyan
        0: begin
          h.green = ChanW'(off);
          h.blue  = ChanW'(Full);
        end
        // cyan to green
        1: begin
          h.green = ChanW'(Full);
          h.blue  = ChanW'(Full - off);
        end
        // green to yellow
        2: begin
          h.red   = ChanW'(off);
          h.green = ChanW'(Full);
        end
        // yellow to red
        3: begin
          h.red   = ChanW'(Full);
          h.green = ChanW'(Full - off);
        end
        // red to magenta
        4: begin
          h.red  = ChanW'(Full);
          h.blue = ChanW'(off);
        end
        // magenta back to blue
        default: begin
          h.red  = ChanW'(Full - off);
          h.blue = ChanW'(Full);
        end
      endcase
    end
    return h;
  endfunction

  // random sample, mostly aimed at the live part of the scale
  function automatic logic signed [DataW-1:0] pick_sample();
    longint          t;
    longint          m;
    longint unsigned span;
    longint unsigned r;
    longint          v;
    t = scale_low;
    m = scale_top;
    r = {$urandom, $urandom};
    v = $signed($urandom);
    if (m > t) begin
      span = longint'(m - t);
      case ($urandom_range(9))
        0, 1: v = $signed($urandom);
        2: begin
          case ($urandom_range(5))
            0: v = MinS32;
            1: v = MaxS32;
            2: v = t;
            3: v = m;
            4: v = t - 1;
            default: v = m + 1;
          endcase
        end
        3, 4: v = t + longint'($urandom_range(4000)) - 100;
        9: v = m + longint'(r % (4 * span + 1));
        default: v = t + longint'(r % (span + 1));
      endcase
    end
    return DataW'(v);
  endfunction

  // drain: nothing left to send and every color back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || start || hues_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [DataW-1:0] data,
                            output logic [DataW-1:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write both registers and read them back
  task automatic set_scale(longint low, longint top);
    logic [DataW-1:0] rd;
    apb_access(1'b1, AddrThreshold, DataW'(low), rd);
    apb_access(1'b1, AddrMax, DataW'(top), rd);
    scale_low = DataW'(low);
    scale_top = DataW'(top);
    settings_used++;
    apb_access(1'b0, AddrThreshold, '0, rd);
    if (rd !== scale_low) begin
      if (mismatches < 10) $display("threshold readback: exp %h got %h", scale_low, rd);
      mismatches++;
    end
    apb_access(1'b0, AddrMax, '0, rd);
    if (rd !== scale_top) begin
      if (mismatches < 10) $display("max readback: exp %h got %h", scale_top, rd);
      mismatches++;
    end
    @(negedge clk_i);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) samples_to_send = {samples_to_send, pick_sample()};
  endtask

  task automatic random_valid_scale();
    longint t;
    longint d;
    t = $signed($urandom);
    d = ($urandom_range(3) == 0) ? longint'($urandom) + 1 : longint'($urandom_range(1, 2000));
    if (t + d > MaxS32) t = MaxS32 - d;
    set_scale(t, t + d);
  endtask

  task automatic random_broken_scale();
    longint t;
    longint m;
    t = $signed($urandom);
    m = t - longint'($urandom_range(1000));
    if (m < MinS32) m = MinS32;
    set_scale(t, m);
  endtask

  // driver: one sample beat per accepting edge
  always @(posedge clk_i) begin
    if (start && !busy) begin
      hues_due = {hues_due, hue_of(sample_value, scale_low, scale_top)};
      beats_in++;
    end
    if (start && busy) begin
      start <= 1'b1;
    end else if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      start        <= 1'b1;
      sample_value <= samples_to_send.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: every result beat against the oldest expected color
  always @(posedge clk_i) begin
    hue_beat_t want;
    if (rst_ni && result_valid_o) begin
      beats_out++;
      if (hues_due.size() == 0) begin
        if (mismatches < 10) $display("unexpected color beat r%0d g%0d b%0d err%0d",
                                      red_o, green_o, blue_o, range_error_o);
        mismatches++;
      end else begin
        want = hues_due.pop_front();
        if (want.range_error) range_error_beats++;
        else if (want.red == 0 && want.green == 0 && want.blue == 0) black_beats++;
        if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue ||
            range_error_o !== want.range_error) begin
          if (mismatches < 10)
            $display("color mismatch: exp r%0d g%0d b%0d err%0d got r%0d g%0d b%0d err%0d",
                     want.red, want.green, want.blue, want.range_error,
                     red_o, green_o, blue_o, range_error_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat and no register access
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d colors outstanding", hues_due.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset scale: ring boundaries, wrap and field extremes
    send_idle_pct = 32;
    samples_to_send = '{32'sh80000000, -32'sd1, 32'sd0, 32'sd1, 32'sd13107, 32'sd26214,
                        32'sd39321, 32'sd52428, 32'sd65535, 32'sd65536, 32'sd78642,
                        32'sh7fffffff, 32'sd12345};
    wait_idle();

    // span of 1275 puts every segment edge on a whole sample
    set_scale(-500, 775);
    samples_to_send = '{-32'sd501, -32'sd500, -32'sd246, -32'sd245, -32'sd244, 32'sd10,
                        32'sd265, 32'sd520, 32'sd775, 32'sd1029, 32'sd1030, 32'sd1031};
    wait_idle();

    // sender idles about a third of the time
    queue_random(40);
    wait_idle();
    set_scale(MinS32, MaxS32);
    queue_random(50);
    wait_idle();
    set_scale(0, 1);
    queue_random(50);
    wait_idle();
    set_scale(MaxS32, MinS32);
    queue_random(20);
    wait_idle();

    // sender idles most of the time
    send_idle_pct = 77;
    set_scale(100, 100);
    queue_random(20);
    wait_idle();
    set_scale(MaxS32 - 1, MaxS32);
    queue_random(40);
    wait_idle();
    random_valid_scale();
    queue_random(40);
    wait_idle();
    random_broken_scale();
    queue_random(15);
    wait_idle();

    // back to back, with a full drain after every batch
    send_idle_pct = 0;
    random_valid_scale();
    queue_random(40);
    wait_idle();
    queue_random(40);
    wait_idle();
    random_valid_scale();
    queue_random(30);
    wait_idle();
    set_scale(0, 65535);
    queue_random(30);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (hues_due.size() != 0) mismatches += hues_due.size();
    $display("summary: %0d samples in, %0d colors out over %0d scale settings",
             beats_in, beats_out, settings_used);
    $display("summary: %0d range-error colors, %0d black colors, %0d mismatches",
             range_error_beats, black_beats, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
